// ===== sv/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, command codes and character constants for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_SHEX = 2'd0;
    localparam logic [1:0] CMD_SDEC = 2'd1;
    localparam logic [1:0] CMD_UHEX = 2'd2;
    localparam logic [1:0] CMD_CHAR = 2'd3;

    // Character and word constants
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_MINUS  = 8'h2d;
    localparam logic [7:0]  CH_LOWER_A = 8'h61;
    localparam logic [31:0] MAG_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;  // ceil(2^35 / 10)
    localparam int          RECIP_SHIFT = 35;

    // Digit buffer sizing
    localparam int          MAX_DIGITS = 10;
    localparam int          CNT_W      = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new input transaction
        logic step;   // one divide-by-ten step
        logic emit;   // push one character into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;  // current divide step leaves a zero quotient
        logic emit_last;  // next character is the final one
        logic out_free;   // output register can take a character
    } t_dp_stat;

    // Map a 4-bit digit to its lower-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_LOWER_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: accepts a transaction, runs the decimal divide loop when
// needed, then paces character output against the output handshake.
// ----------------------------------------------------------------------------
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    output logic       o_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_command == CMD_SDEC) ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/itoa_dpath.sv =====
// ----------------------------------------------------------------------------
// itoa_dpath
// Datapath: sign handling, digit extraction into a small buffer, and the
// output register that drives the result channel.
// ----------------------------------------------------------------------------
module itoa_dpath
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_command,
    input  logic [31:0] i_value,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    logic             r_is_char;
    logic [7:0]       r_byte;
    logic             r_sign_pend;
    logic [31:0]      r_mag;
    logic [3:0]       r_buf [MAX_DIGITS];
    logic [CNT_W-1:0] r_cnt;
    logic             r_o_valid;
    logic [7:0]       r_o_char;
    logic             r_o_last;

    logic             neg;
    logic [31:0]      load_mag;
    logic [CNT_W-1:0] hex_cnt;
    logic [63:0]      prod;
    logic [31:0]      quot;
    logic [31:0]      rem_full;
    logic [3:0]       rem;
    logic [CNT_W-1:0] rd_idx;
    logic             emit_last;
    logic [7:0]       emit_char;

    // Sign and magnitude of the incoming word
    always_comb begin
        neg      = (i_command == CMD_SHEX || i_command == CMD_SDEC) && i_value[31];
        load_mag = i_value;
        if (i_command == CMD_SHEX) begin
            load_mag = i_value & MAG_MASK;
        end else if (neg) begin
            load_mag = ~i_value + 32'd1;
        end
    end

    // Count significant hex nibbles, at least one
    always_comb begin
        hex_cnt = CNT_W'(1);
        for (int i = 1; i < 8; i++) begin
            if (load_mag[4*i +: 4] != 4'd0) begin
                hex_cnt = CNT_W'(i + 1);
            end
        end
    end

    // Divide by ten through the reciprocal
    always_comb begin
        prod     = {32'd0, r_mag} * {32'd0, RECIP_TEN};
        quot     = prod[63:RECIP_SHIFT] == '0 ? 32'd0 : 32'(prod[63:RECIP_SHIFT]);
        rem_full = r_mag - ((quot << 3) + (quot << 1));
        rem      = rem_full[3:0];
    end

    // Select the next character
    always_comb begin
        rd_idx    = r_cnt - CNT_W'(1);
        emit_last = r_is_char || (!r_sign_pend && r_cnt == CNT_W'(1));
        if (r_is_char) begin
            emit_char = r_byte;
        end else if (r_sign_pend) begin
            emit_char = CH_MINUS;
        end else begin
            emit_char = digit_char(r_buf[rd_idx]);
        end
    end

    assign o_stat.conv_done = (quot == 32'd0);
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = !r_o_valid || i_ready;

    // Load, divide steps and digit drain
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_char   <= (i_command == CMD_CHAR);
            r_byte      <= i_value[7:0];
            r_sign_pend <= neg;
            r_mag       <= load_mag;
            if (i_command == CMD_SDEC) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= hex_cnt;
                for (int i = 0; i < 8; i++) begin
                    r_buf[i] <= load_mag[4*i +: 4];
                end
            end
        end else if (i_cmd.step) begin
            r_buf[r_cnt] <= rem;
            r_cnt        <= r_cnt + CNT_W'(1);
            r_mag        <= quot;
        end else if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (!r_is_char) begin
                r_cnt <= rd_idx;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_char <= emit_char;
            r_o_last <= emit_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_char = r_o_char;
    assign o_last     = r_o_last;

endmodule

// ===== sv/integer_to_ascii_formatter.sv =====
// For hex and char modes the sequencer goes from idle straight to the emit
// state; decimal mode first runs one divide step per digit.
// A new transaction is accepted only once the previous one's last character
// has entered the output register; decimal digits use the single divide unit.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
// drops o_valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Converts a 32-bit word to ASCII hex, decimal or a raw character, one
// character per output transaction, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import itoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    itoa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // Conversion datapath and output register
    itoa_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

// ===== tb/itoa_text_checker.sv =====
// ----------------------------------------------------------------------------
// itoa_text_checker
// Watches both channels of the integer to ASCII formatter. Each accepted
// input transaction is expanded into the characters it should produce.
// Each accepted output transaction is compared with the oldest of them.
// ----------------------------------------------------------------------------
module itoa_text_checker
    import itoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_char,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char pending_text[$];
    t_text_char head;
    int         mismatch_count = 0;
    int         pending_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // Expand one word into its expected characters, most significant first
    function automatic void format_text(input logic [1:0] cmd, input logic [31:0] word);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [31:0] mag;
        logic [3:0]  digit;
        logic        hex;
        mag = word;
        hex = (cmd != CMD_SDEC);
        if (cmd == CMD_CHAR) begin
            text.push_back(word[7:0]);
        end else begin
            // Sign-magnitude for hex, two's complement for decimal
            if (word[31] && cmd == CMD_SHEX) begin
                text.push_back(CH_MINUS);
                mag = word & MAG_MASK;
            end else if (word[31] && cmd == CMD_SDEC) begin
                text.push_back(CH_MINUS);
                mag = ~word + 32'd1;
            end
            if (mag == 32'd0) begin
                digits.push_back(CH_ZERO);
            end
            while (mag != 32'd0) begin
                if (hex) begin
                    digit = mag[3:0];
                    mag   = mag >> 4;
                end else begin
                    digit = 4'(mag % 32'd10);
                    mag   = mag / 32'd10;
                end
                if (digit < 4'd10) begin
                    digits.push_front(CH_ZERO + 8'(digit));
                end else begin
                    digits.push_front(CH_LOWER_A + 8'(digit) - 8'd10);
                end
            end
            foreach (digits[i]) begin
                text.push_back(digits[i]);
            end
        end
        foreach (text[i]) begin
            pending_text.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    // Compare accepted characters, then queue the text of accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_text.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected char %02h last %0b with no text pending",
                                 $realtime, i_out_char, i_last);
                    end
                end else begin
                    head = pending_text.pop_front();
                    if (i_out_char !== head.ch || i_last !== head.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: char mismatch: expected %02h last %0b, got %02h last %0b",
                                     $realtime, head.ch, head.last, i_out_char, i_last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                format_text(i_command, i_value);
            end
            pending_count = pending_text.size();
        end
    end

endmodule

// ===== tb/integer_to_ascii_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives directed edge words and random words in every command through the
// formatter, with random gaps on both channels, and reports the verdict of
// the text checker.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb
    import itoa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 248;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_char;
    logic        o_last;

    int          fail_count;
    int          pending_chars;
    int          cycle_count = 0;
    logic        quiet = 1'b0;

    integer_to_ascii_formatter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    itoa_text_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_char   (o_out_char),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stall the output channel now and then, never during the quiet stretch
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = quiet || ($urandom_range(99) >= 6);
        end
    end

    // Present one word, hold it until accepted, return at the next falling edge
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] word);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_command = cmd;
        i_value   = word;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random word, weighted toward digit-count boundaries and negative values
    function automatic logic [31:0] pick_word();
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(255));
            2: begin
                if ($urandom_range(1) == 1) begin
                    k = $urandom_range(9);
                    repeat (k) p = p * 32'd10;
                end else begin
                    k = $urandom_range(7);
                    p = p << (4 * k);
                end
                return p + 32'($urandom_range(2)) - 32'd1;
            end
            3: return {1'b1, 31'($urandom)};
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_command = CMD_SHEX;
        i_value   = 32'd0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Signed hex: zero, negative zero, extremes, digit boundary
        send_word(CMD_SHEX, 32'h0000_0000);
        send_word(CMD_SHEX, 32'h8000_0000);
        send_word(CMD_SHEX, 32'hffff_ffff);
        send_word(CMD_SHEX, 32'h7fff_ffff);
        send_word(CMD_SHEX, 32'h0000_0010);
        // Signed decimal: zero, most negative, minus one, billion boundary
        send_word(CMD_SDEC, 32'h0000_0000);
        send_word(CMD_SDEC, 32'h8000_0000);
        send_word(CMD_SDEC, 32'hffff_ffff);
        send_word(CMD_SDEC, 32'd1000000000);
        send_word(CMD_SDEC, 32'd999999999);
        send_word(CMD_SDEC, 32'h7fff_ffff);
        send_word(CMD_SDEC, 32'd9);
        send_word(CMD_SDEC, 32'd10);
        // Unsigned hex: zero, all ones, top bit, widest and narrow boundaries
        send_word(CMD_UHEX, 32'h0000_0000);
        send_word(CMD_UHEX, 32'hffff_ffff);
        send_word(CMD_UHEX, 32'h8000_0000);
        send_word(CMD_UHEX, 32'h0fff_ffff);
        send_word(CMD_UHEX, 32'h0000_0010);
        // Character: zero low byte, all-ones byte, upper bits ignored
        send_word(CMD_CHAR, 32'h0000_0100);
        send_word(CMD_CHAR, 32'h0000_00ff);
        send_word(CMD_CHAR, 32'h1234_5641);
        send_word(CMD_CHAR, 32'hffff_ff00);

        // Random words, with a stretch of back-to-back traffic in the middle
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= 100 && n < 170);
            send_word(2'($urandom_range(3)), pick_word());
        end
        quiet   = 1'b0;
        i_valid = 1'b0;

        // Drain, then leave room for any stray character
        while (pending_chars != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
